>>> rtl/core/maal_pkg.sv
// Shared types and constants for the MAC address allow list.
// No dependencies; used by the store, the sequencer and the top level.
package maal_pkg;

  localparam int MAC_W         = 48;
  localparam int FUNC_W        = 2;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_REMOVE   = 2'd1,
    FUNC_CONTAINS = 2'd2
  } func_t;

endpackage

>>> rtl/core/maal_ram.sv
// Entry store for the allow list: one write port, one registered read port.
// Depends on maal_pkg for the entry width.
module maal_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [maal_pkg::MAC_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [maal_pkg::MAC_W-1:0] rd_data
);

  logic [maal_pkg::MAC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/maal_seq.sv
// Sequencer for the allow list: scans the store with one comparator,
// then appends, shifts entries down, or reports. Depends on maal_pkg.
module maal_seq #(
  parameter int CAPACITY = 16,
  parameter int ADDR_W   = 4,
  parameter int CNT_W    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [maal_pkg::FUNC_W-1:0]       func,
  input  logic [maal_pkg::MAC_W-1:0]        mac,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic                              ok,
  output logic [maal_pkg::ENTRY_COUNT_W-1:0] entry_count,
  output logic                              wr_en,
  output logic [ADDR_W-1:0]                 wr_addr,
  output logic [maal_pkg::MAC_W-1:0]        wr_data,
  output logic                              rd_en,
  output logic [ADDR_W-1:0]                 rd_addr,
  input  logic [maal_pkg::MAC_W-1:0]        rd_data
);

  localparam int ECW = maal_pkg::ENTRY_COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  state_t                     state;
  maal_pkg::func_t            op;
  logic [maal_pkg::MAC_W-1:0] key;
  logic [ADDR_W-1:0]          idx;
  logic [CNT_W-1:0]           count;
  logic                       found;
  logic                       res_ok;

  logic [ADDR_W-1:0] idx_inc;
  logic [CNT_W-1:0]  idx_ext;
  logic              has_room;

  assign idx_inc   = idx + 1'b1;
  assign idx_ext   = CNT_W'(idx);
  assign has_room  = count < CNT_W'(CAPACITY);
  assign req_ready = (state == S_IDLE);

  always_comb begin
    rd_en   = (state == S_SCAN) || (state == S_SHIFT_RD);
    rd_addr = (state == S_SHIFT_RD) ? idx_inc : idx;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (state == S_DECIDE && op == maal_pkg::FUNC_ADD && !found && has_room) begin
      wr_en   = 1'b1;
      wr_addr = count[ADDR_W-1:0];
      wr_data = key;
    end else if (state == S_SHIFT_WR) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op     <= maal_pkg::func_t'(func);
            key    <= mac;
            idx    <= '0;
            found  <= 1'b0;
            res_ok <= 1'b0;
            if (func != maal_pkg::FUNC_ADD && func != maal_pkg::FUNC_REMOVE &&
                func != maal_pkg::FUNC_CONTAINS) begin
              state <= S_FINISH;
            end else if (count == '0) begin
              state <= S_DECIDE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_data == key) begin
            found <= 1'b1;
            state <= S_DECIDE;
          end else if ((idx_ext + CNT_W'(1)) == count) begin
            state <= S_DECIDE;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end
        end
        S_DECIDE: begin
          state <= S_FINISH;
          unique case (op)
            maal_pkg::FUNC_ADD: begin
              if (found) begin
                res_ok <= 1'b1;
              end else if (has_room) begin
                count  <= count + CNT_W'(1);
                res_ok <= 1'b1;
              end
            end
            maal_pkg::FUNC_REMOVE: begin
              if (found) begin
                if ((idx_ext + CNT_W'(1)) < count) begin
                  state <= S_SHIFT_RD;
                end else begin
                  count  <= count - CNT_W'(1);
                  res_ok <= 1'b1;
                end
              end
            end
            maal_pkg::FUNC_CONTAINS: begin
              res_ok <= found;
            end
            default: begin
              res_ok <= 1'b0;
            end
          endcase
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx <= idx_inc;
          if ((idx_ext + CNT_W'(2)) < count) begin
            state <= S_SHIFT_RD;
          end else begin
            count  <= count - CNT_W'(1);
            res_ok <= 1'b1;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid   <= 1'b1;
            ok          <= res_ok;
            entry_count <= ECW'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/mac_address_allow_list.sv
// MAC address allow list: add, remove and lookup of 48-bit addresses.
// Each request scans the stored entries in order and stops at a match; a remove
// that hits then shifts the later entries down; an unused opcode goes to the response.
// One beat in flight, accepted only idle: a new request is taken after the last response issues.
// The scan and the shift share one store read port; the scan uses one comparator.
// Reset clears the entry count and the response valid; the store is not cleared.
module mac_address_allow_list #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [maal_pkg::FUNC_W-1:0]        func,
  input  logic [maal_pkg::MAC_W-1:0]         mac,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic                               ok,
  output logic [maal_pkg::ENTRY_COUNT_W-1:0] entry_count
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [maal_pkg::MAC_W-1:0] wr_data;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [maal_pkg::MAC_W-1:0] rd_data;

  maal_seq #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (func),
    .mac         (mac),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .ok          (ok),
    .entry_count (entry_count),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  maal_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a beat while busy");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("not idle after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !wr_en)
    else $error("store written while idle");

endmodule
